// File: rtl/core/sha512_pkg.sv
// ============================================================================
// SHA-512 core package
// Round constants, initial hash value and round helper functions.
// ============================================================================
package sha512_pkg;

    localparam int WordWidth  = 64;
    localparam int NumRounds  = 80;
    localparam int RoundBits  = 7;
    localparam int BlockWords = 16;
    localparam int SlotBits   = 4;

    typedef logic [WordWidth-1:0] word_t;

    // memory port request toward the schedule window
    typedef struct packed {
        logic                wr_en;
        logic [SlotBits-1:0] wr_addr;
        word_t               wr_data;
        logic [SlotBits-1:0] rd_addr0;
        logic [SlotBits-1:0] rd_addr1;
        logic [SlotBits-1:0] rd_addr2;
        logic [SlotBits-1:0] rd_addr3;
    } win_req_t;

    function automatic word_t k512(input logic [RoundBits-1:0] idx);
        word_t k;
        case (idx)
            7'd0:  k = 64'h428a2f98d728ae22; 7'd1:  k = 64'h7137449123ef65cd;
            7'd2:  k = 64'hb5c0fbcfec4d3b2f; 7'd3:  k = 64'he9b5dba58189dbbc;
            7'd4:  k = 64'h3956c25bf348b538; 7'd5:  k = 64'h59f111f1b605d019;
            7'd6:  k = 64'h923f82a4af194f9b; 7'd7:  k = 64'hab1c5ed5da6d8118;
            7'd8:  k = 64'hd807aa98a3030242; 7'd9:  k = 64'h12835b0145706fbe;
            7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
            7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
            7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
            7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
            7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
            7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
            7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
            7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
            7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
            7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
            7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
            7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
            7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
            7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
            7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
            7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
            7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
            7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
            7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
            7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
            7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
            7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
            7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
            7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
            7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
            7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
            7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
            7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
            7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
            7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
            7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
            7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
            7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
            7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
            7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
            default: k = '0;
        endcase
        return k;
    endfunction

    function automatic word_t iv512(input logic [2:0] idx);
        word_t v;
        case (idx)
            3'd0: v = 64'h6a09e667f3bcc908;
            3'd1: v = 64'hbb67ae8584caa73b;
            3'd2: v = 64'h3c6ef372fe94f82b;
            3'd3: v = 64'ha54ff53a5f1d36f1;
            3'd4: v = 64'h510e527fade682d1;
            3'd5: v = 64'h9b05688c2b3e6c1f;
            3'd6: v = 64'h1f83d9abfb41bd6b;
            3'd7: v = 64'h5be0cd19137e2179;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic word_t rotr(input word_t x, input int n);
        return (x >> n) | (x << (WordWidth - n));
    endfunction

    function automatic word_t sig0(input word_t x);
        return rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
    endfunction

    function automatic word_t sig1(input word_t x);
        return rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
    endfunction

    function automatic word_t bsig0(input word_t x);
        return rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
    endfunction

    function automatic word_t bsig1(input word_t x);
        return rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
    endfunction

endpackage

// File: rtl/core/sha512_window.sv
// ============================================================================
// SHA-512 schedule window
// 16 x 64 message schedule memory: one write port, four registered reads.
// ============================================================================
module sha512_window (
    input  logic                 aclk,
    input  sha512_pkg::win_req_t req,
    output sha512_pkg::word_t    rd_data0,
    output sha512_pkg::word_t    rd_data1,
    output sha512_pkg::word_t    rd_data2,
    output sha512_pkg::word_t    rd_data3
);

    sha512_pkg::word_t mem [sha512_pkg::BlockWords];

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd_data0 <= mem[req.rd_addr0];
        rd_data1 <= mem[req.rd_addr1];
        rd_data2 <= mem[req.rd_addr2];
        rd_data3 <= mem[req.rd_addr3];
    end

endmodule

// File: rtl/core/sha512_block_compress_core.sv
// ============================================================================
// SHA-512 block compression core
// Collects 16 message words, runs 80 rounds, emits digest after final block.
// ============================================================================
// Sequence: 16 accepted words, then for each round a schedule memory read
// state and a round state, then the hash add, then 8 digest words.
// Each round waits on the registered read of the schedule window. One block
// at a time: no message word is accepted while a block is compressed or emitted.
// Reset: hash state loads the initial hash value; counters and control clear.
module sha512_block_compress_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // message_word
    input  logic [1:0]  s_tuser,   // [0] first_block, [1] final_block
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // digest_word
    output logic        m_tlast    // digest_last
);

    typedef enum logic [4:0] {
        ST_LOAD  = 5'b00001,
        ST_READ  = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_ADD   = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [sha512_pkg::SlotBits-1:0]  word_cnt_reg;
    logic [sha512_pkg::RoundBits-1:0] round_reg;
    logic                             final_reg;
    logic [2:0]                       emit_reg;
    sha512_pkg::word_t                h_reg [8];
    sha512_pkg::word_t                v_reg [8];

    sha512_pkg::win_req_t req;
    sha512_pkg::word_t w16, w15, w7, w2, wt;
    logic [sha512_pkg::SlotBits-1:0] slot;

    assign slot = round_reg[sha512_pkg::SlotBits-1:0];

    always_comb begin
        req.wr_en    = 1'b0;
        req.wr_addr  = word_cnt_reg;
        req.wr_data  = s_tdata;
        req.rd_addr0 = slot;
        req.rd_addr1 = slot + 4'd1;
        req.rd_addr2 = slot + 4'd9;
        req.rd_addr3 = slot + 4'd14;
        if (state_reg == ST_LOAD) begin
            req.wr_en = s_tvalid;
        end else if (state_reg == ST_ROUND && round_reg >= 7'd16) begin
            req.wr_en   = 1'b1;
            req.wr_addr = slot;
            req.wr_data = wt;
        end
    end

    sha512_window u_window (
        .aclk     (aclk),
        .req      (req),
        .rd_data0 (w16),
        .rd_data1 (w15),
        .rd_data2 (w7),
        .rd_data3 (w2)
    );

    assign wt = (round_reg < 7'd16) ? w16
              : w16 + sha512_pkg::sig0(w15) + w7 + sha512_pkg::sig1(w2);

    sha512_pkg::word_t t1, t2;
    always_comb begin
        t1 = v_reg[7] + sha512_pkg::bsig1(v_reg[4])
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
           + sha512_pkg::k512(round_reg) + wt;
        t2 = sha512_pkg::bsig0(v_reg[0])
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    assign s_tready = (state_reg == ST_LOAD);
    assign m_tvalid = (state_reg == ST_EMIT);
    assign m_tdata  = h_reg[emit_reg];
    assign m_tlast  = (emit_reg == 3'd7);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:  if (s_tvalid && word_cnt_reg == 4'd15) state_next = ST_READ;
            ST_READ:  state_next = ST_ROUND;
            ST_ROUND: state_next = (round_reg == 7'd79) ? ST_ADD : ST_READ;
            ST_ADD:   state_next = final_reg ? ST_EMIT : ST_LOAD;
            ST_EMIT:  if (m_tready && emit_reg == 3'd7) state_next = ST_LOAD;
            default:  state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            word_cnt_reg <= '0;
            round_reg    <= '0;
            final_reg    <= 1'b0;
            emit_reg     <= '0;
            for (int i = 0; i < 8; i++) begin
                h_reg[i] <= sha512_pkg::iv512(3'(i));
                v_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            case (state_reg)
                ST_LOAD: begin
                    if (s_tvalid) begin
                        word_cnt_reg <= word_cnt_reg + 4'd1;
                        if (word_cnt_reg == 4'd0 && s_tuser[0]) begin
                            for (int i = 0; i < 8; i++) begin
                                h_reg[i] <= sha512_pkg::iv512(3'(i));
                                v_reg[i] <= sha512_pkg::iv512(3'(i));
                            end
                        end else if (word_cnt_reg == 4'd0) begin
                            for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
                        end
                        if (word_cnt_reg == 4'd15) final_reg <= s_tuser[1];
                    end
                end
                ST_ROUND: begin
                    v_reg[7] <= v_reg[6];
                    v_reg[6] <= v_reg[5];
                    v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2];
                    v_reg[2] <= v_reg[1];
                    v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + t2;
                    round_reg <= (round_reg == 7'd79) ? 7'd0 : round_reg + 7'd1;
                end
                ST_ADD: begin
                    for (int i = 0; i < 8; i++) h_reg[i] <= h_reg[i] + v_reg[i];
                    emit_reg <= '0;
                end
                ST_EMIT: begin
                    if (m_tready) emit_reg <= emit_reg + 3'd1;
                end
                default: ;
            endcase
        end
    end

    ap_round_zero_in_load: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_LOAD |-> round_reg == '0) else $error("round count not idle");
    ap_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_LOAD |-> !s_tready) else $error("ready while busy");
    ap_block_start: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_READ && round_reg == '0 |-> word_cnt_reg == '0)
        else $error("block started mid-word");
    ap_emit_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> state_reg == ST_LOAD)
        else $error("emit did not finish");

endmodule
